FILE: src/segmented_send_with_ack_retry_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segmented send controller
// Concurrent checks clocked on clk; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_SEND_WITH_ACK_RETRY_MACROS_SVH
`define SEGMENTED_SEND_WITH_ACK_RETRY_MACROS_SVH
`ifndef SYNTHESIS
// check that is off while rst is high
`define SSAR_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssar check failed");
// check that also holds during reset
`define SSAR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ssar check failed");
`else
`define SSAR_ASSERT(name, prop)
`define SSAR_ASSERT_ALWAYS(name, prop)
`endif
`endif

FILE: src/ssar_pkg.sv
// ----------------------------------------------------------------------------
// ssar_pkg
// Types, codes and constants shared by the segmented send controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ssar_pkg;

  localparam int unsigned SEGMENT_BYTES = 50;
  localparam int unsigned HEADER_BYTES  = 7;
  localparam int unsigned MAX_TRIES     = 4;

  // written count = header + payload + trailing check byte
  localparam int unsigned REPORT_EXTRA = HEADER_BYTES + 1;

  // ceil(len / SEGMENT_BYTES) via reciprocal multiply, exact for 15-bit sums
  localparam int unsigned SEG_RECIP_SHIFT = 18;
  localparam int unsigned SEG_RECIP =
    ((1 << SEG_RECIP_SHIFT) + SEGMENT_BYTES - 1) / SEGMENT_BYTES;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_REPORT  = 2'd1;
  localparam logic [1:0] OP_ACK     = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_COLLISION  = 3'd1;
  localparam logic [2:0] ST_SHORT      = 3'd2;
  localparam logic [2:0] ST_NO_ACK     = 3'd3;
  localparam logic [2:0] ST_BUSY       = 3'd4;

  localparam logic RK_SEGMENT = 1'b0;
  localparam logic RK_STATUS  = 1'b1;

  localparam logic [1:0] CFG_OWN_ADDRESS       = 2'd0;
  localparam logic [1:0] CFG_BROADCAST_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_COLLISION_CHECK   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [13:0] message_length;
    logic [7:0]  destination;
    logic        is_response;
    logic [7:0]  bytes_written;
    logic        collision_seen;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  sender_address;
    logic [7:0]  receiver_address;
    logic        packet_kind;
    logic [7:0]  message_id;
    logic [7:0]  total_segments;
    logic [7:0]  segment_number;
    logic [13:0] segment_offset;
    logic [5:0]  segment_length;
    logic [2:0]  send_status;
  } out_item_t;

  // classified event as it waits between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  seg_count;
    logic [13:0] length;
    logic [7:0]  destination;
    logic        is_response;
    logic [7:0]  bytes_written;
    logic        collision_seen;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] broadcast_address;
    logic       collision_check_enable;
  } cfg_t;

  // payload bytes of the segment that starts at offset
  function automatic logic [5:0] seg_len_of(input logic [13:0] length,
                                            input logic [13:0] offset);
    logic [13:0] rem;
    rem = (length > offset) ? (length - offset) : 14'd0;
    return (rem < 14'(SEGMENT_BYTES)) ? rem[5:0] : 6'(SEGMENT_BYTES);
  endfunction

endpackage

`default_nettype wire

FILE: src/ssar_front.sv
// ----------------------------------------------------------------------------
// ssar_front
// Classifies an incoming event and works out the segment count of a start.
// ----------------------------------------------------------------------------
`default_nettype none

module ssar_front (
  input  var ssar_pkg::in_item_t item,
  output var ssar_pkg::q_entry_t entry
);

  logic [14:0] len_up;
  logic [27:0] prod;
  logic [9:0]  quot;

  always_comb begin
    len_up = {1'b0, item.message_length} + 15'(ssar_pkg::SEGMENT_BYTES - 1);
    prod   = 28'(len_up) * 28'(ssar_pkg::SEG_RECIP);
    quot   = prod[ssar_pkg::SEG_RECIP_SHIFT +: 10];
  end

  always_comb begin
    entry.op             = item.operation;
    entry.seg_count      = (quot > 10'd255) ? 8'd255 : quot[7:0];
    entry.length         = item.message_length;
    entry.destination    = item.destination;
    entry.is_response    = item.is_response;
    entry.bytes_written  = item.bytes_written;
    entry.collision_seen = item.collision_seen;
  end

endmodule

`default_nettype wire

FILE: src/ssar_queue.sv
// ----------------------------------------------------------------------------
// ssar_queue
// Small FIFO of classified events between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segmented_send_with_ack_retry_macros.svh"

module ssar_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  var logic               clk,
  input  var logic               rst,
  input  var logic               push,
  input  var ssar_pkg::q_entry_t push_data,
  output var logic               full,
  input  var logic               pop,
  output var logic               head_valid,
  output var ssar_pkg::q_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssar_pkg::q_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // count is unknown before the first reset edge
  `SSAR_ASSERT_ALWAYS(a_count_in_range, rst || count <= CNT_W'(DEPTH))
  `SSAR_ASSERT(a_push_grows, push && !pop |=> count == $past(count) + 1'b1)
  `SSAR_ASSERT(a_pop_shrinks, pop && !push |=> count == $past(count) - 1'b1)

endmodule

`default_nettype wire

FILE: src/ssar_back.sv
// ----------------------------------------------------------------------------
// ssar_back
// Message state machine: segments, reports, acks, retries and final status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segmented_send_with_ack_retry_macros.svh"

module ssar_back (
  input  var logic                clk,
  input  var logic                rst,
  input  var ssar_pkg::cfg_t      cfg,
  input  var logic                head_valid,
  input  var ssar_pkg::q_entry_t  head,
  output var logic                pop,
  output var logic                out_valid,
  input  var logic                out_stall,
  output var ssar_pkg::out_item_t out_data
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_REPORT = 2'd1;
  localparam logic [1:0] PH_ACK    = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [7:0]  message_counter, message_counter_next;
  logic [7:0]  current_segment, current_segment_next;
  logic [7:0]  segment_count, segment_count_next;
  logic [13:0] stored_length, stored_length_next;
  logic [13:0] seg_offset, seg_offset_next;
  logic [2:0]  try_count, try_count_next;
  logic [7:0]  stored_destination, stored_destination_next;
  logic        stored_kind, stored_kind_next;

  logic        slot_free;
  logic        emit_seg;
  logic        emit_stat;
  logic        advance;
  logic [2:0]  status;
  logic [7:0]  expect_bytes;
  ssar_pkg::out_item_t res;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = head_valid && slot_free;

  assign expect_bytes = 8'(ssar_pkg::seg_len_of(stored_length, seg_offset))
                      + 8'(ssar_pkg::REPORT_EXTRA);

  always_comb begin
    phase_next              = phase;
    message_counter_next    = message_counter;
    current_segment_next    = current_segment;
    segment_count_next      = segment_count;
    stored_length_next      = stored_length;
    seg_offset_next         = seg_offset;
    try_count_next          = try_count;
    stored_destination_next = stored_destination;
    stored_kind_next        = stored_kind;
    emit_seg  = 1'b0;
    emit_stat = 1'b0;
    advance   = 1'b0;
    status    = ssar_pkg::ST_OK;

    if (pop) begin
      unique case (head.op)
        ssar_pkg::OP_START: begin
          if (phase != PH_IDLE) begin
            emit_stat = 1'b1;
            status    = ssar_pkg::ST_BUSY;
          end else begin
            stored_length_next      = head.length;
            stored_destination_next = head.destination;
            stored_kind_next        = head.is_response;
            message_counter_next    = message_counter + 8'd1;
            segment_count_next      = head.seg_count;
            seg_offset_next         = '0;
            if (head.seg_count == 8'd0) begin
              current_segment_next = 8'd0;
              try_count_next       = 3'd0;
              emit_stat            = 1'b1;
            end else begin
              current_segment_next = 8'd1;
              try_count_next       = 3'd1;
              emit_seg             = 1'b1;
            end
          end
        end
        ssar_pkg::OP_REPORT: begin
          if (phase == PH_REPORT) begin
            // short write outranks collision
            if (head.bytes_written != expect_bytes) begin
              emit_stat = 1'b1;
              status    = ssar_pkg::ST_SHORT;
            end else if (head.collision_seen && cfg.collision_check_enable) begin
              emit_stat = 1'b1;
              status    = ssar_pkg::ST_COLLISION;
            end else if (stored_destination == cfg.broadcast_address) begin
              advance = 1'b1;
            end else begin
              phase_next = PH_ACK;
            end
          end
        end
        ssar_pkg::OP_ACK: begin
          if (phase == PH_ACK) begin
            advance = 1'b1;
          end
        end
        ssar_pkg::OP_TIMEOUT: begin
          if (phase == PH_ACK) begin
            if (try_count >= 3'(ssar_pkg::MAX_TRIES)) begin
              emit_stat = 1'b1;
              status    = ssar_pkg::ST_NO_ACK;
            end else begin
              try_count_next = try_count + 3'd1;
              emit_seg       = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      if (advance) begin
        if (current_segment < segment_count) begin
          current_segment_next = current_segment + 8'd1;
          try_count_next       = 3'd1;
          seg_offset_next      = seg_offset + 14'(ssar_pkg::SEGMENT_BYTES);
          emit_seg             = 1'b1;
        end else begin
          emit_stat = 1'b1;
        end
      end

      if (emit_stat) begin
        phase_next = PH_IDLE;
      end else if (emit_seg) begin
        phase_next = PH_REPORT;
      end
    end
  end

  always_comb begin
    res = '0;
    if (emit_stat) begin
      res.result_kind = ssar_pkg::RK_STATUS;
      res.send_status = status;
    end else begin
      res.result_kind      = ssar_pkg::RK_SEGMENT;
      res.sender_address   = cfg.own_address;
      res.receiver_address = stored_destination_next;
      res.packet_kind      = stored_kind_next;
      res.message_id       = message_counter_next - 8'd1;
      res.total_segments   = segment_count_next;
      res.segment_number   = current_segment_next;
      res.segment_offset   = seg_offset_next;
      res.segment_length   = ssar_pkg::seg_len_of(stored_length_next, seg_offset_next);
      res.send_status      = ssar_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      message_counter    <= '0;
      current_segment    <= '0;
      segment_count      <= '0;
      stored_length      <= '0;
      seg_offset         <= '0;
      try_count          <= '0;
      stored_destination <= '0;
      stored_kind        <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      phase              <= phase_next;
      message_counter    <= message_counter_next;
      current_segment    <= current_segment_next;
      segment_count      <= segment_count_next;
      stored_length      <= stored_length_next;
      seg_offset         <= seg_offset_next;
      try_count          <= try_count_next;
      stored_destination <= stored_destination_next;
      stored_kind        <= stored_kind_next;
      if (emit_seg || emit_stat) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_seg || emit_stat) begin
      out_data <= res;
    end
  end

  `SSAR_ASSERT(a_tries_bounded,
    phase != PH_IDLE |-> try_count != 3'd0 && try_count <= 3'(ssar_pkg::MAX_TRIES))
  `SSAR_ASSERT(a_segment_in_message,
    phase != PH_IDLE |-> current_segment != 8'd0 && current_segment <= segment_count)
  `SSAR_ASSERT(a_descriptor_number,
    out_valid && out_data.result_kind == ssar_pkg::RK_SEGMENT |-> out_data.segment_number != 8'd0 && out_data.segment_number <= out_data.total_segments)
  `SSAR_ASSERT(a_status_clean,
    out_valid && out_data.result_kind == ssar_pkg::RK_STATUS |-> out_data.total_segments == 8'd0 && out_data.segment_length == 6'd0)

endmodule

`default_nettype wire

FILE: src/segmented_send_with_ack_retry.sv
// Segmented send controller with ack and retry.
// in channel (in_valid/in_stall/in_data): one event per transaction; start,
//   transmit report, ack received or ack timeout. A start splits the message
//   into 50-byte segments; yields first descriptor, or status if empty or busy.
// out channel (out_valid/out_stall/out_data): zero or one result per event,
//   either a segment descriptor or the final message status.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no message event is in flight.
// A taken event is written into the queue on the accepting edge; the message
//   state machine then moves its result into the output register.
// Throughput: one event per cycle while the queue is not full; the state
//   machine handles one queued event per cycle when output is free or draining.
// out_stall holds the output register; the state machine waits, the queue
//   fills, and in_stall rises once the QUEUE_DEPTH entries are in use.
// Reset: synchronous, clears the queue, the output register, the message
//   state and loads the register defaults (own 1, broadcast 255, check on).
// ----------------------------------------------------------------------------
// segmented_send_with_ack_retry
// Top level: config registers, event front, queue and message back end.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_send_with_ack_retry #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                in_valid,
  output var logic                in_stall,
  input  var ssar_pkg::in_item_t  in_data,
  output var logic                out_valid,
  input  var logic                out_stall,
  output var ssar_pkg::out_item_t out_data,
  input  var logic                cfg_valid,
  output var logic                cfg_ready,
  input  var logic [1:0]          cfg_index,
  input  var logic [7:0]          cfg_data
);

  ssar_pkg::cfg_t     cfg;
  ssar_pkg::q_entry_t fe_entry;
  ssar_pkg::q_entry_t q_head;
  logic               q_full;
  logic               q_head_valid;
  logic               q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address            <= 8'd1;
      cfg.broadcast_address      <= 8'd255;
      cfg.collision_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssar_pkg::CFG_OWN_ADDRESS:       cfg.own_address <= cfg_data;
        ssar_pkg::CFG_BROADCAST_ADDRESS: cfg.broadcast_address <= cfg_data;
        ssar_pkg::CFG_COLLISION_CHECK:   cfg.collision_check_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ssar_front u_front (
    .item  (in_data),
    .entry (fe_entry)
  );

  ssar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !q_full),
    .push_data  (fe_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ssar_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
